// File: rtl/wav_header_check_and_sample_unpack_defines.svh
// Assertion macros for the WAV header checker and sample unpacker.
// Used by the top level only; no other dependencies.
`ifndef WAV_HEADER_CHECK_AND_SAMPLE_UNPACK_DEFINES_SVH
`define WAV_HEADER_CHECK_AND_SAMPLE_UNPACK_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define WAVHC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define WAVHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wavhc_pkg.sv
// Shared types and constants for the WAV header checker and sample unpacker.
// No dependencies.
`timescale 1ns / 1ps

package wavhc_pkg;

    // Input transfer: one file byte plus end-of-file mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } wavhc_in_t;

    // Outcome code reported with each result
    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD     = 3'd2,
        ST_EARLY   = 3'd3,
        ST_SURPLUS = 3'd4
    } status_t;

    // Result transfer
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  sample_byte;
        logic        header_done;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [31:0] payload_size;
        status_t     status;
    } wavhc_out_t;

    // Parser phase; code 3 is unused and behaves like skip
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_SKIP   = 2'd2
    } phase_t;

    // Tags as little-endian 32-bit words
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_SIZE_PCM   = 32'd16;
    localparam logic [15:0] AUDIO_FMT_PCM  = 16'd1;
    localparam logic [31:0] RIFF_SIZE_BIAS = 32'd36;
    localparam logic [15:0] SAMPLE_BITS_16 = 16'd16;
    localparam logic [15:0] SAMPLE_BITS_32 = 16'd32;
    localparam logic [7:0]  SIGN_FLIP      = 8'h80;

    // Header length and the offsets of the last byte of each field
    localparam logic [5:0] HDR_LEN        = 6'd44;
    localparam logic [5:0] POS_RIFF_TAG   = 6'd3;
    localparam logic [5:0] POS_RIFF_SIZE  = 6'd7;
    localparam logic [5:0] POS_WAVE_TAG   = 6'd11;
    localparam logic [5:0] POS_FMT_TAG    = 6'd15;
    localparam logic [5:0] POS_FMT_SIZE   = 6'd19;
    localparam logic [5:0] POS_AUDIO_FMT  = 6'd21;
    localparam logic [5:0] POS_CHANNELS   = 6'd23;
    localparam logic [5:0] POS_RATE       = 6'd27;
    localparam logic [5:0] POS_BYTE_RATE  = 6'd31;
    localparam logic [5:0] POS_ALIGN      = 6'd33;
    localparam logic [5:0] POS_BITS       = 6'd35;
    localparam logic [5:0] POS_DATA_TAG   = 6'd39;
    localparam logic [5:0] POS_DATA_SIZE  = 6'd43;

endpackage

// File: rtl/wavhc_in_stage.sv
// Input register slice: holds one accepted byte for the parse stage.
// Depends on wavhc_pkg.
`timescale 1ns / 1ps

module wavhc_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wavhc_pkg::wavhc_in_t s_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output wavhc_pkg::wavhc_in_t q_item
);
    import wavhc_pkg::*;

    logic      valid_reg;
    wavhc_in_t item_reg;

    // Accept when empty or when the held byte moves on this cycle
    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: rtl/wavhc_core.sv
// Parse stage: header field capture and checks, data byte sign flip,
// outcome codes. Depends on wavhc_pkg.
`timescale 1ns / 1ps

module wavhc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  wavhc_pkg::wavhc_in_t  item,
    output wavhc_pkg::wavhc_out_t result
);
    import wavhc_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [5:0]  pos_reg,      pos_next;
    logic [31:0] shift_reg,    shift_next;
    logic [31:0] riff_reg,     riff_next;
    logic [15:0] chan_reg,     chan_next;
    logic [31:0] rate_reg,     rate_next;
    logic [31:0] byterate_reg, byterate_next;
    logic [15:0] align_reg,    align_next;
    logic [15:0] bits_reg,     bits_next;
    logic [31:0] size_reg,     size_next;
    logic [31:0] count_reg,    count_next;
    logic [31:0] prod_reg;

    logic [31:0] shift_word;
    logic [5:0]  pos_inc;
    logic [31:0] count_inc;
    logic [31:0] chan_bits;
    logic        bad;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_done;
    status_t     out_status;

    assign shift_word = {item.in_byte, shift_reg[31:8]};
    assign pos_inc    = pos_reg + 6'd1;
    assign count_inc  = count_reg + 32'd1;
    // channels * bits, 16x16 product; bits come from the current byte
    assign chan_bits  = {16'd0, chan_reg} * {16'd0, shift_word[31:16]};

    // Block align * sample rate; both are settled well before the bits field
    always_ff @(posedge aclk) begin
        prod_reg <= {16'd0, align_reg} * rate_reg;
    end

    // Next state and result for the byte in the input register
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        riff_next     = riff_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        byterate_next = byterate_reg;
        align_next    = align_reg;
        bits_next     = bits_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        bad           = 1'b0;
        out_valid     = 1'b0;
        out_byte      = 8'd0;
        out_done      = 1'b0;
        out_status    = ST_BUSY;

        case (phase_reg)
            PH_HEADER: begin
                shift_next = shift_word;
                case (pos_reg)
                    POS_RIFF_TAG:  bad = (shift_word != TAG_RIFF);
                    POS_RIFF_SIZE: riff_next = shift_word;
                    POS_WAVE_TAG:  bad = (shift_word != TAG_WAVE);
                    POS_FMT_TAG:   bad = (shift_word != TAG_FMT);
                    POS_FMT_SIZE:  bad = (shift_word != FMT_SIZE_PCM);
                    POS_AUDIO_FMT: bad = (shift_word[31:16] != AUDIO_FMT_PCM);
                    POS_CHANNELS:  chan_next = shift_word[31:16];
                    POS_RATE:      rate_next = shift_word;
                    POS_BYTE_RATE: byterate_next = shift_word;
                    POS_ALIGN:     align_next = shift_word[31:16];
                    POS_BITS: begin
                        bits_next = shift_word[31:16];
                        bad = ({13'd0, align_reg} != chan_bits[31:3])
                            || (byterate_reg != prod_reg);
                    end
                    POS_DATA_TAG:  bad = (shift_word != TAG_DATA);
                    POS_DATA_SIZE: begin
                        size_next = shift_word;
                        bad = (riff_reg != (shift_word + RIFF_SIZE_BIAS));
                    end
                    default: ;
                endcase
                pos_next = pos_inc;
                if (bad) begin
                    out_status = ST_BAD;
                    phase_next = PH_SKIP;
                end else if (pos_inc >= HDR_LEN) begin
                    out_done   = 1'b1;
                    phase_next = PH_DATA;
                    count_next = 32'd0;
                    if (item.end_of_file) begin
                        out_status = (size_next == 32'd0) ? ST_OK : ST_EARLY;
                    end
                end else if (item.end_of_file) begin
                    out_status = ST_EARLY;
                end
            end
            PH_DATA: begin
                if (count_reg < size_reg) begin
                    out_valid = 1'b1;
                    out_byte  = item.in_byte;
                    // for 16- and 32-bit samples the top byte of each little-endian sample gets its sign flipped
                    if (bits_reg == SAMPLE_BITS_16 && count_reg[0]) begin
                        out_byte = out_byte ^ SIGN_FLIP;
                    end
                    if (bits_reg == SAMPLE_BITS_32 && (count_reg[1:0] == 2'b11)) begin
                        out_byte = out_byte ^ SIGN_FLIP;
                    end
                    count_next = count_inc;
                    if (item.end_of_file) begin
                        out_status = (count_inc == size_reg) ? ST_OK : ST_EARLY;
                    end
                end else begin
                    out_status = ST_SURPLUS;
                    phase_next = PH_SKIP;
                end
            end
            default: ;   // skip until end of file
        endcase

        // End of file: next byte opens a new file
        if (item.end_of_file) begin
            phase_next = PH_HEADER;
            pos_next   = 6'd0;
            shift_next = 32'd0;
            count_next = 32'd0;
        end
    end

    // Result reports the header registers after this byte
    always_comb begin
        result.data_valid    = out_valid;
        result.sample_byte   = out_byte;
        result.header_done   = out_done;
        result.channel_count = chan_next;
        result.rate_hz       = rate_next;
        result.sample_bits   = bits_next;
        result.payload_size  = size_next;
        result.status        = out_status;
    end

    // Parser state; header fields are visible at the output so reset them too
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= 6'd0;
            shift_reg    <= 32'd0;
            riff_reg     <= 32'd0;
            chan_reg     <= 16'd0;
            rate_reg     <= 32'd0;
            byterate_reg <= 32'd0;
            align_reg    <= 16'd0;
            bits_reg     <= 16'd0;
            size_reg     <= 32'd0;
            count_reg    <= 32'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            riff_reg     <= riff_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            byterate_reg <= byterate_next;
            align_reg    <= align_next;
            bits_reg     <= bits_next;
            size_reg     <= size_next;
            count_reg    <= count_next;
        end
    end

endmodule

// File: rtl/wavhc_out_stage.sv
// Result register: holds one finished result until the m_ side takes it.
// Depends on wavhc_pkg.
`timescale 1ns / 1ps

module wavhc_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  d_valid,
    output logic                  d_ready,
    input  wavhc_pkg::wavhc_out_t d_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wavhc_pkg::wavhc_out_t m_item
);
    import wavhc_pkg::*;

    logic       valid_reg;
    wavhc_out_t item_reg;

    // Load when empty or when the current result is taken this cycle
    assign d_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (d_ready) begin
            valid_reg <= d_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (d_valid && d_ready) begin
            item_reg <= d_item;
        end
    end

endmodule

// File: rtl/wav_header_check_and_sample_unpack.sv
// Top level of the WAV header checker and sample unpacker.
// Depends on wavhc_pkg, wavhc_in_stage, wavhc_core, wavhc_out_stage and
// wav_header_check_and_sample_unpack_defines.svh.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_item : in_byte, end_of_file
//   m_      | out | m_valid / m_ready  | m_item : one result per byte
//
// One byte per cycle while m_ready stays high; a taken byte passes the input
// register, then parse logic into the result register, and leaves as a result.
// The whole header check and data pass sit in the single parse stage; the
// block-align * sample-rate product is registered ahead of the bits field.
// Reset clears the parser to the header phase and all header fields to zero.
// With m_ready low both registers fill, then s_ready falls.
`timescale 1ns / 1ps
`include "wav_header_check_and_sample_unpack_defines.svh"

module wav_header_check_and_sample_unpack (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wavhc_pkg::wavhc_in_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wavhc_pkg::wavhc_out_t m_item
);
    import wavhc_pkg::*;

    logic       q_valid;
    logic       d_ready;
    logic       step;
    wavhc_in_t  q_item;
    wavhc_out_t d_item;

    // Parse stage advances when a byte is held and the result slot frees
    assign step = q_valid && d_ready;

    wavhc_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (d_ready),
        .q_item  (q_item)
    );

    wavhc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (q_item),
        .result  (d_item)
    );

    wavhc_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (q_valid),
        .d_ready (d_ready),
        .d_item  (d_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Every parsed byte lands in the result register
    `WAVHC_ASSERT_NEXT(a_step_gives_result, aclk, aresetn, step, m_valid, "parsed byte lost")
    // Input only backs up behind a stalled, full result register
    `WAVHC_ASSERT_SAME(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output backpressure")
    // Header completion never carries data, a bad header or surplus
    `WAVHC_ASSERT_SAME(a_done_clean, aclk, aresetn, m_valid && m_item.header_done, !m_item.data_valid && m_item.status != ST_BAD && m_item.status != ST_SURPLUS, "inconsistent header_done result")

endmodule
